FILE: src/rcdda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdda_pkg
// Shared types and constants of the grid raycaster core: payload words,
// register indexes, sequencer states and the map and datapath sizes.
// ----------------------------------------------------------------------------
package rcdda_pkg;

    localparam int MAP_DIM   = 32;
    localparam int MAP_AW    = $clog2(MAP_DIM);
    localparam int MAP_CELLS = MAP_DIM * MAP_DIM;
    localparam int ADDR_W    = $clog2(MAP_CELLS);
    // map coordinate, signed, holds -1 .. MAP_DIM and the camera cell
    localparam int COORD_W   = ((MAP_AW > 5) ? MAP_AW : 5) + 2;
    // side distance accumulators: up to about 2*MAP_DIM steps of 16 bits
    localparam int SIDE_W    = MAP_AW + 18;
    // grid line to camera distance, Q6.8
    localparam int EDGE_W    = ((MAP_AW + 9) > 14) ? (MAP_AW + 9) : 14;
    // divider numerator and quotient width
    localparam int DIV_NW    = EDGE_W + 14;
    localparam int ACC_W     = 52;
    localparam int REM_W     = 30;
    localparam int DEN_W     = 18;
    localparam int SQRT_STEPS = 26;
    localparam int CNT_W     = $clog2(DIV_NW);
    localparam int CFG_IDX_W = 4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAMERA_X, REG_CAMERA_Y, REG_VIEW_DIR_X, REG_VIEW_DIR_Y,
        REG_PLANE_DIR_X, REG_PLANE_DIR_Y, REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_CAM_DIV, ST_RAY_X, ST_RAY_Y, ST_SQ_X, ST_SQ_Y,
        ST_SQRT, ST_DLX_DIV, ST_DLY_DIV, ST_SD_X, ST_SD_Y, ST_WALK_STEP,
        ST_WALK_TEST, ST_PERP_DIV, ST_LINE_DIV, ST_OUT
    } state_t;

    typedef struct packed {
        logic       action;
        logic [9:0] column;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [7:0] cell_value;
    } in_word_t;

    typedef struct packed {
        logic [9:0]  column_out;
        logic [9:0]  slice_top;
        logic [9:0]  slice_bottom;
        logic        wall_side;
        logic [15:0] wall_distance;
        logic        no_hit;
    } out_word_t;

endpackage

FILE: src/raycast_column_dda_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_column_dda_core
// Grid raycaster: map cell writes and one wall slice per cast column.
// ----------------------------------------------------------------------------
// After reset the core clears its 1024-entry map, one cell a cycle, and holds
// s_ready low until the map is clear. A map write word leaves the core in idle. A cast
// word runs on one sequencer around a shared restoring subtract unit (divider
// and square root, one bit a cycle) and one multiplier. It runs five 28-bit
// divisions and a 26-step root, and walks the map a cell per step, each step
// being a map read and a test. One result word is held in an output register;
// the core takes the next word while it waits to be taken.
module raycast_column_dda_core
    import rcdda_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    // configuration
    logic [12:0]        camera_x_reg, camera_y_reg;
    logic signed [15:0] view_dir_x_reg, view_dir_y_reg;
    logic signed [15:0] plane_dir_x_reg, plane_dir_y_reg;
    logic [10:0]        screen_width_reg, screen_height_reg;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              m_valid_reg;
    out_word_t         out_reg;

    // datapath
    logic [ACC_W-1:0]  acc_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIV_NW-1:0] res_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [9:0]        col_reg;
    logic              neg_reg;
    logic signed [17:0] rx_reg, ry_reg;
    logic [35:0]       sq_reg;
    logic [25:0]       len_reg;
    logic [15:0]       dlx_reg, dly_reg, perp_reg;
    logic [18:0]       line_reg;
    logic [SIDE_W-1:0] sdx_reg, sdy_reg;
    logic signed [COORD_W-1:0] mx_reg, my_reg;
    logic              side_reg, no_hit_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        map_mem [MAP_CELLS];

    function automatic logic [10:0] clamp_dim(input logic [10:0] v);
        if (v == 11'd0) return 11'd1;
        else if (v > 11'd1024) return 11'd1024;
        else return v;
    endfunction

    function automatic logic [15:0] sat16(input logic [DIV_NW-1:0] v);
        return (|v[DIV_NW-1:16]) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [ACC_W-1:0] div_load(input logic [DIV_NW-1:0] num);
        return {num, {(ACC_W-DIV_NW){1'b0}}};
    endfunction

    logic [10:0] w_eff, h_eff;
    logic [9:0]  half;
    logic        s_fire, out_load;

    assign w_eff     = clamp_dim(screen_width_reg);
    assign h_eff     = clamp_dim(screen_height_reg);
    assign half      = h_eff[10:1];
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign out_load  = !m_valid_reg || m_ready;

    // column to camera-plane offset numerator
    logic signed [11:0] cam_diff;
    logic [10:0]        cam_abs;
    assign cam_diff = $signed({1'b0, s_data.column, 1'b0}) - $signed({1'b0, w_eff});
    assign cam_abs  = cam_diff[11] ? 11'(-cam_diff) : cam_diff[10:0];

    // shared subtract unit: restoring divide and square root steps
    logic              is_sqrt, unit_busy, unit_last, unit_reload, sub_ge;
    logic [REM_W-1:0]  sub_a, sub_b, rem_new;
    logic [REM_W:0]    sub_diff;
    logic [DIV_NW-1:0] res_new;
    logic [ACC_W-1:0]  acc_shift;

    assign is_sqrt   = (state_reg == ST_SQRT);
    assign unit_busy = is_sqrt || state_reg == ST_CAM_DIV || state_reg == ST_DLX_DIV ||
                       state_reg == ST_DLY_DIV || state_reg == ST_PERP_DIV ||
                       state_reg == ST_LINE_DIV;
    assign unit_last = (cnt_reg == '0);
    // last step of a pass that loads the next operation straight away
    assign unit_reload = unit_last && (is_sqrt || state_reg == ST_DLX_DIV ||
                                       state_reg == ST_PERP_DIV);
    assign sub_a     = is_sqrt ? {rem_reg[REM_W-3:0], acc_reg[ACC_W-1 -: 2]}
                               : {rem_reg[REM_W-2:0], acc_reg[ACC_W-1]};
    assign sub_b     = is_sqrt ? REM_W'({res_reg[SQRT_STEPS-1:0], 2'b01})
                               : REM_W'(den_reg);
    assign sub_diff  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge    = !sub_diff[REM_W];
    assign rem_new   = sub_ge ? sub_diff[REM_W-1:0] : sub_a;
    assign res_new   = {res_reg[DIV_NW-2:0], sub_ge};
    assign acc_shift = is_sqrt ? {acc_reg[ACC_W-3:0], 2'b00} : {acc_reg[ACC_W-2:0], 1'b0};

    // shared multiplier
    logic signed [26:0] cam;
    logic signed [27:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [46:0] mul_p;
    logic [17:0]        ax, ay;
    logic [8:0]         frac_x, frac_y;

    assign cam    = neg_reg ? -$signed({2'b00, res_reg[24:0]}) : $signed({2'b00, res_reg[24:0]});
    assign ax     = rx_reg[17] ? 18'(-rx_reg) : 18'(rx_reg);
    assign ay     = ry_reg[17] ? 18'(-ry_reg) : 18'(ry_reg);
    assign frac_x = rx_reg[17] ? {1'b0, camera_x_reg[7:0]} : 9'd256 - {1'b0, camera_x_reg[7:0]};
    assign frac_y = ry_reg[17] ? {1'b0, camera_y_reg[7:0]} : 9'd256 - {1'b0, camera_y_reg[7:0]};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RAY_X: begin
                mul_a = 28'(cam);
                mul_b = 19'(plane_dir_x_reg);
            end
            ST_RAY_Y: begin
                mul_a = 28'(cam);
                mul_b = 19'(plane_dir_y_reg);
            end
            ST_SQ_X: begin
                mul_a = $signed({10'b0, ax});
                mul_b = $signed({1'b0, ax});
            end
            ST_SQ_Y: begin
                mul_a = $signed({10'b0, ay});
                mul_b = $signed({1'b0, ay});
            end
            ST_SD_X: begin
                mul_a = $signed({19'b0, frac_x});
                mul_b = $signed({3'b0, dlx_reg});
            end
            ST_SD_Y: begin
                mul_a = $signed({19'b0, frac_y});
                mul_b = $signed({3'b0, dly_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // ray component: dir + floor(plane*cam / 2^14), saturated to 18 bits
    logic signed [15:0] dir_sel;
    logic signed [33:0] ray_sum;
    logic signed [17:0] ray_sat;
    assign dir_sel = (state_reg == ST_RAY_X) ? view_dir_x_reg : view_dir_y_reg;
    assign ray_sum = 34'($signed(mul_p[46:14])) + 34'(dir_sel);
    assign ray_sat = (ray_sum > 34'sd131071)  ? 18'sh1FFFF :
                     (ray_sum < -34'sd131072) ? 18'sh20000 : ray_sum[17:0];

    // walk step
    logic x_inf, y_inf, step_x, walk_out, cam_out, hit;
    logic signed [COORD_W-1:0] mx_n, my_n;
    logic [SIDE_W-1:0] sdx_n, sdy_n;
    logic [ADDR_W-1:0] rd_addr;

    assign x_inf  = (ax == '0);
    assign y_inf  = (ay == '0);
    assign step_x = !x_inf && (y_inf || sdx_reg < sdy_reg);
    assign mx_n   = step_x ? mx_reg + (rx_reg[17] ? -COORD_W'(1) : COORD_W'(1)) : mx_reg;
    assign my_n   = step_x ? my_reg : my_reg + (ry_reg[17] ? -COORD_W'(1) : COORD_W'(1));
    assign sdx_n  = step_x ? sdx_reg + SIDE_W'(dlx_reg) : sdx_reg;
    assign sdy_n  = (!step_x && !y_inf) ? sdy_reg + SIDE_W'(dly_reg) : sdy_reg;
    assign walk_out = mx_n < 0 || my_n < 0 ||
                      mx_n >= $signed(COORD_W'(MAP_DIM)) || my_n >= $signed(COORD_W'(MAP_DIM));
    assign cam_out  = mx_reg >= $signed(COORD_W'(MAP_DIM)) ||
                      my_reg >= $signed(COORD_W'(MAP_DIM));
    assign rd_addr  = ADDR_W'(mx_n[MAP_AW-1:0]) * ADDR_W'(MAP_DIM) + ADDR_W'(my_n[MAP_AW-1:0]);
    assign hit      = (rd_data_reg != 8'd0);

    // perpendicular distance numerator: near grid line minus camera
    logic signed [COORD_W-1:0] m_sel;
    logic [MAP_AW:0]   m_plus;
    logic [EDGE_W-1:0] grid_pos, cam_pos, edge_abs;
    assign m_sel    = side_reg ? my_reg : mx_reg;
    assign m_plus   = (MAP_AW+1)'(m_sel[MAP_AW-1:0]) +
                      (MAP_AW+1)'(side_reg ? ry_reg[17] : rx_reg[17]);
    assign grid_pos = EDGE_W'(m_plus) << 8;
    assign cam_pos  = EDGE_W'(side_reg ? camera_y_reg : camera_x_reg);
    assign edge_abs = (grid_pos >= cam_pos) ? grid_pos - cam_pos : cam_pos - grid_pos;

    logic [15:0] perp_new;
    assign perp_new = sat16(res_new);

    // map memory
    logic              mem_we, wr_in_map;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    assign wr_in_map = (32'(s_data.cell_x) < MAP_DIM) && (32'(s_data.cell_y) < MAP_DIM);
    assign mem_we    = (state_reg == ST_CLEAR) ||
                       (s_fire && s_data.action == ACT_WRITE && wr_in_map);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg :
                       ADDR_W'(s_data.cell_x) * ADDR_W'(MAP_DIM) + ADDR_W'(s_data.cell_y);
    assign mem_wdata = (state_reg == ST_CLEAR) ? 8'd0 : s_data.cell_value;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            camera_x_reg      <= 13'd512;
            camera_y_reg      <= 13'd512;
            view_dir_x_reg    <= -16'sd16384;
            view_dir_y_reg    <= 16'sd0;
            plane_dir_x_reg   <= 16'sd0;
            plane_dir_y_reg   <= 16'sd10813;
            screen_width_reg  <= 11'd640;
            screen_height_reg <= 11'd480;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_CAMERA_X:      camera_x_reg      <= cfg_data[12:0];
                REG_CAMERA_Y:      camera_y_reg      <= cfg_data[12:0];
                REG_VIEW_DIR_X:    view_dir_x_reg    <= cfg_data;
                REG_VIEW_DIR_Y:    view_dir_y_reg    <= cfg_data;
                REG_PLANE_DIR_X:   plane_dir_x_reg   <= cfg_data;
                REG_PLANE_DIR_Y:   plane_dir_y_reg   <= cfg_data;
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[10:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == ST_OUT && out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:     if (clr_cnt_reg == ADDR_W'(MAP_CELLS - 1)) state_next = ST_IDLE;
            ST_IDLE:      if (s_fire && s_data.action == ACT_CAST) state_next = ST_CAM_DIV;
            ST_CAM_DIV:   if (unit_last) state_next = ST_RAY_X;
            ST_RAY_X:     state_next = ST_RAY_Y;
            ST_RAY_Y:     state_next = ST_SQ_X;
            ST_SQ_X:      state_next = ST_SQ_Y;
            ST_SQ_Y:      state_next = ST_SQRT;
            ST_SQRT:      if (unit_last) state_next = ST_DLX_DIV;
            ST_DLX_DIV:   if (unit_last) state_next = ST_DLY_DIV;
            ST_DLY_DIV:   if (unit_last) state_next = ST_SD_X;
            ST_SD_X:      state_next = ST_SD_Y;
            ST_SD_Y:      state_next = cam_out ? ST_OUT : ST_WALK_STEP;
            ST_WALK_STEP: state_next = walk_out ? ST_OUT : ST_WALK_TEST;
            ST_WALK_TEST: state_next = hit ? ST_PERP_DIV : ST_WALK_STEP;
            ST_PERP_DIV:  if (unit_last) state_next = ST_LINE_DIV;
            ST_LINE_DIV:  if (unit_last) state_next = ST_OUT;
            ST_OUT:       if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (unit_busy && !unit_reload) begin
            acc_reg <= acc_shift;
            rem_reg <= rem_new;
            res_reg <= res_new;
            cnt_reg <= cnt_reg - 1'b1;
        end
        case (state_reg)
            ST_IDLE: if (s_fire && s_data.action == ACT_CAST) begin
                col_reg <= s_data.column;
                neg_reg <= cam_diff[11];
                acc_reg <= div_load(DIV_NW'({cam_abs, 14'b0}));
                rem_reg <= '0;
                res_reg <= '0;
                cnt_reg <= CNT_W'(DIV_NW - 1);
                den_reg <= DEN_W'(w_eff);
            end
            ST_RAY_X: rx_reg <= ray_sat;
            ST_RAY_Y: ry_reg <= ray_sat;
            ST_SQ_X:  sq_reg <= mul_p[35:0];
            ST_SQ_Y: begin
                acc_reg <= {sq_reg + mul_p[35:0], 16'b0};
                rem_reg <= '0;
                res_reg <= '0;
                cnt_reg <= CNT_W'(SQRT_STEPS - 1);
            end
            ST_SQRT: if (unit_last) begin
                len_reg <= res_new[SQRT_STEPS-1:0];
                acc_reg <= div_load(DIV_NW'(res_new[SQRT_STEPS-1:0]));
                rem_reg <= '0;
                res_reg <= '0;
                cnt_reg <= CNT_W'(DIV_NW - 1);
                den_reg <= ax;
            end
            ST_DLX_DIV: if (unit_last) begin
                dlx_reg <= sat16(res_new);
                acc_reg <= div_load(DIV_NW'(len_reg));
                rem_reg <= '0;
                res_reg <= '0;
                cnt_reg <= CNT_W'(DIV_NW - 1);
                den_reg <= ay;
            end
            ST_DLY_DIV: if (unit_last) dly_reg <= sat16(res_new);
            ST_SD_X: begin
                sdx_reg    <= SIDE_W'(mul_p[23:8]);
                mx_reg     <= COORD_W'(camera_x_reg[12:8]);
                my_reg     <= COORD_W'(camera_y_reg[12:8]);
                side_reg   <= 1'b0;
                no_hit_reg <= 1'b0;
            end
            ST_SD_Y: begin
                sdy_reg <= SIDE_W'(mul_p[23:8]);
                if (cam_out) no_hit_reg <= 1'b1;
            end
            ST_WALK_STEP: begin
                mx_reg   <= mx_n;
                my_reg   <= my_n;
                sdx_reg  <= sdx_n;
                sdy_reg  <= sdy_n;
                side_reg <= !step_x;
                if (walk_out) no_hit_reg <= 1'b1;
            end
            ST_WALK_TEST: if (hit) begin
                acc_reg <= div_load({edge_abs, 14'b0});
                rem_reg <= '0;
                res_reg <= '0;
                cnt_reg <= CNT_W'(DIV_NW - 1);
                den_reg <= side_reg ? ay : ax;
            end
            ST_PERP_DIV: if (unit_last) begin
                perp_reg <= perp_new;
                acc_reg  <= div_load(DIV_NW'({h_eff, 8'b0}));
                rem_reg  <= '0;
                res_reg  <= '0;
                cnt_reg  <= CNT_W'(DIV_NW - 1);
                den_reg  <= (perp_new == 16'd0) ? DEN_W'(1) : DEN_W'(perp_new);
            end
            ST_LINE_DIV: if (unit_last) line_reg <= res_new[18:0];
            default: ;
        endcase
    end

    // result word
    logic [19:0] top_sum;
    logic [9:0]  ds, de;
    assign top_sum = 20'(half) + 20'(line_reg);
    assign ds = (line_reg >= 19'(half)) ? 10'd0 : half - line_reg[9:0];
    assign de = (top_sum >= 20'(h_eff)) ? 10'(h_eff - 11'd1) : top_sum[9:0];

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_load) begin
            out_reg.column_out    <= col_reg;
            out_reg.wall_side     <= side_reg;
            out_reg.no_hit        <= no_hit_reg;
            out_reg.slice_top     <= no_hit_reg ? half : ds;
            out_reg.slice_bottom  <= no_hit_reg ? half : de;
            out_reg.wall_distance <= no_hit_reg ? 16'hFFFF : perp_reg;
        end
    end

endmodule

FILE: src/rcdda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdda_checker
// Port-level checks on the raycaster core, bound to the top level.
// ----------------------------------------------------------------------------
module rcdda_checker
    import rcdda_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // map clearing pass follows every reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("core ready right after reset");

    // the core is not ready right after it takes a cast word
    a_cast_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == ACT_CAST |=> !s_ready)
        else $error("core ready right after a cast word");

    a_miss_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.no_hit |->
            m_data.slice_top == m_data.slice_bottom && m_data.wall_distance == 16'hFFFF)
        else $error("miss word with wall fields");

    a_slice_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.no_hit |-> m_data.slice_top <= m_data.slice_bottom)
        else $error("slice start below end");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped or changed while stalled");

endmodule

bind raycast_column_dda_core rcdda_checker u_rcdda_checker (.*);
